// ===== design/xcfd_pkg.sv =====
// shared types and constants for the xor checked frame decoder
package xcfd_pkg;

    typedef logic [7:0] byte_t;

    localparam byte_t START_BYTE = 8'hFE;

    typedef enum logic [2:0] {
        ST_WAIT,
        ST_FUNC_HI,
        ST_FUNC_LO,
        ST_LEN_HI,
        ST_LEN_LO,
        ST_DATA,
        ST_CHECK,
        ST_READ
    } state_t;

endpackage

// ===== design/xcfd_cell.sv =====
// one byte cell of the payload shift chain
module xcfd_cell
    import xcfd_pkg::*;
(
    input  logic  clk,
    input  logic  shift,
    input  byte_t din,
    output byte_t dout
);

    byte_t data_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            data_reg <= din;
        end
    end

    assign dout = data_reg;

endmodule

// ===== design/xor_checked_frame_decoder_unit.sv =====
// frame decoder top: header parsing, xor check, payload chain and result register
// a word is taken every cycle while a frame is being received, except while the
// checksum word waits for a held result; the checksum word starts a readout of
// PAYLOAD_MAX shifts of the cell chain, one per cycle unless an output word is held,
// with the first PAYLOAD_MAX - length shifts aligning and the rest emitting words
// input is stalled during readout; a zero-length frame gives its result next cycle
// reset clears all control state; the payload chain is not cleared
module xor_checked_frame_decoder_unit
    import xcfd_pkg::*;
#(
    parameter int PAYLOAD_MAX = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] function_code,
    output logic [6:0]  payload_length,
    output logic [5:0]  byte_index,
    output logic [7:0]  payload_byte,
    output logic        has_byte,
    output logic        last_of_frame
);

    localparam logic [15:0] MAX16 = 16'(PAYLOAD_MAX);
    localparam logic [6:0]  MAX7  = 7'(PAYLOAD_MAX);

    state_t      state_reg, state_next;
    logic [15:0] func_reg, func_next;
    logic [15:0] len_reg, len_next;
    logic [6:0]  cnt_reg, cnt_next;
    byte_t       xor_reg, xor_next;
    logic [6:0]  step_reg, step_next;

    logic        out_valid_reg, out_valid_next;
    logic [15:0] out_func_reg, out_func_next;
    logic [6:0]  out_len_reg, out_len_next;
    logic [5:0]  out_idx_reg, out_idx_next;
    byte_t       out_byte_reg, out_byte_next;
    logic        out_has_reg, out_has_next;
    logic        out_last_reg, out_last_next;

    logic        in_acc;
    logic        out_free;
    logic        emit;
    logic        advance;
    logic        shift_en;
    logic        out_load;
    logic [6:0]  skip;
    logic [6:0]  cnt_inc;
    byte_t       chain_q [PAYLOAD_MAX];

    // payload chain: words enter at the tail and move toward cell zero
    for (genvar i = 0; i < PAYLOAD_MAX; i++)
    begin : g_chain
        byte_t cell_din;
        if (i == PAYLOAD_MAX - 1)
        begin : g_tail
            assign cell_din = rx_byte;
        end
        else
        begin : g_mid
            assign cell_din = chain_q[i + 1];
        end
        xcfd_cell u_cell (
            .clk  (clk),
            .shift(shift_en),
            .din  (cell_din),
            .dout (chain_q[i])
        );
    end

    assign in_stall = (state_reg == ST_READ) || ((state_reg == ST_CHECK) && out_valid_reg);
    assign in_acc   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign skip     = MAX7 - len_reg[6:0];
    assign emit     = (state_reg == ST_READ) && (step_reg >= skip);
    assign advance  = (state_reg == ST_READ) && (!emit || out_free);
    assign shift_en = (in_acc && (state_reg == ST_DATA)) || advance;
    assign cnt_inc  = cnt_reg + 7'd1;

    always_comb
    begin
        state_next    = state_reg;
        func_next     = func_reg;
        len_next      = len_reg;
        cnt_next      = cnt_reg;
        xor_next      = xor_reg;
        step_next     = step_reg;
        out_load      = 1'b0;
        out_func_next = out_func_reg;
        out_len_next  = out_len_reg;
        out_idx_next  = out_idx_reg;
        out_byte_next = out_byte_reg;
        out_has_next  = out_has_reg;
        out_last_next = out_last_reg;

        case (state_reg)
            ST_WAIT:
            begin
                if (in_acc && (rx_byte == START_BYTE))
                begin
                    cnt_next   = 7'd0;
                    xor_next   = START_BYTE;
                    state_next = ST_FUNC_HI;
                end
            end
            ST_FUNC_HI:
            begin
                if (in_acc)
                begin
                    func_next  = {rx_byte, 8'h00};
                    xor_next   = xor_reg ^ rx_byte;
                    state_next = ST_FUNC_LO;
                end
            end
            ST_FUNC_LO:
            begin
                if (in_acc)
                begin
                    func_next  = {func_reg[15:8], rx_byte};
                    xor_next   = xor_reg ^ rx_byte;
                    state_next = ST_LEN_HI;
                end
            end
            ST_LEN_HI:
            begin
                if (in_acc)
                begin
                    len_next   = {rx_byte, 8'h00};
                    xor_next   = xor_reg ^ rx_byte;
                    state_next = ST_LEN_LO;
                end
            end
            ST_LEN_LO:
            begin
                if (in_acc)
                begin
                    len_next = {len_reg[15:8], rx_byte};
                    xor_next = xor_reg ^ rx_byte;
                    if (len_next > MAX16)
                    begin
                        state_next = ST_WAIT;
                    end
                    else if (len_next == 16'd0)
                    begin
                        state_next = ST_CHECK;
                    end
                    else
                    begin
                        state_next = ST_DATA;
                    end
                end
            end
            ST_DATA:
            begin
                if (in_acc)
                begin
                    xor_next = xor_reg ^ rx_byte;
                    cnt_next = cnt_inc;
                    if ({9'd0, cnt_inc} >= len_reg)
                    begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                if (in_acc)
                begin
                    state_next = ST_WAIT;
                    if (rx_byte == xor_reg)
                    begin
                        if (len_reg == 16'd0)
                        begin
                            // empty frame: single marker word without data
                            out_load      = 1'b1;
                            out_func_next = func_reg;
                            out_len_next  = 7'd0;
                            out_idx_next  = 6'd0;
                            out_byte_next = 8'h00;
                            out_has_next  = 1'b0;
                            out_last_next = 1'b1;
                        end
                        else
                        begin
                            step_next  = 7'd0;
                            state_next = ST_READ;
                        end
                    end
                end
            end
            ST_READ:
            begin
                if (advance)
                begin
                    if (emit)
                    begin
                        out_load      = 1'b1;
                        out_func_next = func_reg;
                        out_len_next  = len_reg[6:0];
                        out_idx_next  = 6'(step_reg - skip);
                        out_byte_next = chain_q[0];
                        out_has_next  = 1'b1;
                        out_last_next = (step_reg == MAX7 - 7'd1);
                    end
                    step_next = step_reg + 7'd1;
                    if (step_reg == MAX7 - 7'd1)
                    begin
                        state_next = ST_WAIT;
                    end
                end
            end
            default:
            begin
                state_next = ST_WAIT;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_WAIT;
            func_reg      <= 16'd0;
            len_reg       <= 16'd0;
            cnt_reg       <= 7'd0;
            xor_reg       <= START_BYTE;
            step_reg      <= 7'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            func_reg      <= func_next;
            len_reg       <= len_next;
            cnt_reg       <= cnt_next;
            xor_reg       <= xor_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_func_reg <= out_func_next;
        out_len_reg  <= out_len_next;
        out_idx_reg  <= out_idx_next;
        out_byte_reg <= out_byte_next;
        out_has_reg  <= out_has_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid      = out_valid_reg;
    assign function_code  = out_func_reg;
    assign payload_length = out_len_reg;
    assign byte_index     = out_idx_reg;
    assign payload_byte   = out_byte_reg;
    assign has_byte       = out_has_reg;
    assign last_of_frame  = out_last_reg;

    // the final word of a readout always returns the parser to hunting
    a_last_ends_read: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && out_last_next) |=> (state_reg == ST_WAIT))
        else $error("readout did not end after last word");

    a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> (step_reg < MAX7))
        else $error("readout step beyond chain length");

    a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_has_reg) |-> (out_last_reg && (out_len_reg == 7'd0)))
        else $error("word without data is not a lone empty-frame marker");

    a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_has_reg) |-> ({1'b0, out_idx_reg} < out_len_reg))
        else $error("byte index outside frame length");

endmodule

// ===== tb/xor_checked_frame_decoder_unit_tb.sv =====
// testbench for the xor checked frame decoder: directed table, random frames, scoreboard
`timescale 1ns / 100ps

module xor_checked_frame_decoder_unit_tb
    import xcfd_pkg::*;
;

    localparam int PAYLOAD_MAX = 64;
    localparam int CYCLE_LIMIT = 400000;
    localparam int IDLE_PCT = 29;
    localparam int RANDOM_WORDS = 245;

    typedef struct packed {
        logic [15:0] func;
        logic [6:0]  len;
        logic [5:0]  idx;
        logic [7:0]  data;
        logic        has;
        logic        last;
    } frame_word_t;

    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_NO_WORD,
        ROW_ONE_WORD
    } row_mode_t;

    typedef struct packed {
        byte_t       data;
        row_mode_t   mode;
        frame_word_t word;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  rx_byte = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [15:0] function_code;
    logic [6:0]  payload_length;
    logic [5:0]  byte_index;
    logic [7:0]  payload_byte;
    logic        has_byte;
    logic        last_of_frame;

    frame_word_t pending_words[$];
    stim_row_t   stim_rows[$];
    int          errors = 0;
    int          cycles = 0;
    int          words_sent = 0;
    bit          calm = 1'b0;

    // decoder mirror
    state_t      ph = ST_WAIT;
    logic [15:0] code_q = '0;
    logic [15:0] len_q = '0;
    logic [6:0]  cnt = '0;
    byte_t       sum = START_BYTE;
    byte_t       store [PAYLOAD_MAX];

    xor_checked_frame_decoder_unit #(
        .PAYLOAD_MAX(PAYLOAD_MAX)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .rx_byte(rx_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .function_code(function_code),
        .payload_length(payload_length),
        .byte_index(byte_index),
        .payload_byte(payload_byte),
        .has_byte(has_byte),
        .last_of_frame(last_of_frame)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < IDLE_PCT);
    end

    // advance the mirror by one word, queue the words a good checksum releases
    task automatic decode_word(input byte_t b, input bit keep);
        frame_word_t w;
        begin
            case (ph)
                ST_WAIT:
                begin
                    if (b == START_BYTE)
                    begin
                        cnt = '0;
                        sum = START_BYTE;
                        ph = ST_FUNC_HI;
                    end
                end
                ST_FUNC_HI:
                begin
                    code_q = {b, 8'h00};
                    sum = sum ^ b;
                    ph = ST_FUNC_LO;
                end
                ST_FUNC_LO:
                begin
                    code_q[7:0] = b;
                    sum = sum ^ b;
                    ph = ST_LEN_HI;
                end
                ST_LEN_HI:
                begin
                    len_q = {b, 8'h00};
                    sum = sum ^ b;
                    ph = ST_LEN_LO;
                end
                ST_LEN_LO:
                begin
                    len_q[7:0] = b;
                    sum = sum ^ b;
                    if (len_q > PAYLOAD_MAX)
                        ph = ST_WAIT;
                    else if (len_q == 0)
                        ph = ST_CHECK;
                    else
                        ph = ST_DATA;
                end
                ST_DATA:
                begin
                    if (cnt < PAYLOAD_MAX)
                        store[cnt[5:0]] = b;
                    sum = sum ^ b;
                    cnt = cnt + 7'd1;
                    if (cnt >= len_q)
                        ph = ST_CHECK;
                end
                ST_CHECK:
                begin
                    if (b == sum && keep)
                    begin
                        if (len_q == 0)
                        begin
                            w = {code_q, 7'd0, 6'd0, 8'h00, 1'b0, 1'b1};
                            pending_words.push_back(w);
                        end
                        else
                        begin
                            for (int i = 0; i < len_q; i++)
                            begin
                                w.func = code_q;
                                w.len = len_q[6:0];
                                w.idx = i[5:0];
                                w.data = store[i];
                                w.has = 1'b1;
                                w.last = (i + 1 == len_q);
                                pending_words.push_back(w);
                            end
                        end
                    end
                    ph = ST_WAIT;
                end
                default:
                    ph = ST_WAIT;
            endcase
        end
    endtask

    // offer one word with random idle cycles, return at the edge that takes it
    task automatic push_word(input byte_t b, input bit counts, input bit keep);
        begin
            while (!calm && $urandom_range(0, 99) < IDLE_PCT)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid <= 1'b1;
            rx_byte <= b;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            decode_word(b, keep);
            if (counts)
                words_sent++;
        end
    endtask

    // one random frame: mostly well formed, some broken, some line noise
    task automatic send_frame();
        int          kind;
        int          pick;
        int          n_pay;
        logic [15:0] code;
        logic [15:0] frame_len;
        byte_t       word;
        byte_t       csum;
        byte_t       q[$];
        begin
            kind = $urandom_range(0, 99);
            if (kind < 8)
            begin
                repeat ($urandom_range(1, 4))
                begin
                    word = byte_t'($urandom_range(0, 254));
                    if (word == START_BYTE)
                        word = 8'hFF;
                    push_word(word, 1'b0, 1'b1);
                end
                return;
            end
            pick = $urandom_range(0, 99);
            code = (pick < 5) ? 16'h0000 : (pick < 10) ? 16'hFFFF : 16'($urandom);
            pick = $urandom_range(0, 99);
            if (kind < 14)
                frame_len = 16'($urandom_range(PAYLOAD_MAX + 1, 16'hFFFF));
            else if (pick < 10)
                frame_len = 16'd0;
            else if (pick < 14)
                frame_len = 16'(PAYLOAD_MAX);
            else if (pick < 24)
                frame_len = 16'($urandom_range(9, PAYLOAD_MAX - 1));
            else
                frame_len = 16'($urandom_range(1, 8));
            if (kind < 14)
                n_pay = 0;
            else if (kind < 22 || kind >= 26)
                n_pay = frame_len;
            else
                n_pay = (frame_len == 0) ? 0 : $urandom_range(0, frame_len - 1);
            q.push_back(START_BYTE);
            q.push_back(code[15:8]);
            q.push_back(code[7:0]);
            q.push_back(frame_len[15:8]);
            q.push_back(frame_len[7:0]);
            for (int i = 0; i < n_pay; i++)
                q.push_back(byte_t'($urandom));
            csum = 8'h00;
            foreach (q[i])
                csum = csum ^ q[i];
            if (kind >= 26)
                q.push_back(csum);
            else if (kind >= 14 && kind < 22)
                q.push_back(csum ^ byte_t'($urandom_range(1, 255)));
            foreach (q[i])
                push_word(q[i], 1'b1, 1'b1);
        end
    endtask

    function automatic void add_row(input byte_t d, input row_mode_t m, input frame_word_t w);
        stim_row_t r;
        r.data = d;
        r.mode = m;
        r.word = w;
        stim_rows.push_back(r);
    endfunction

    function automatic void note_field(input string what, input logic [15:0] want,
                                       input logic [15:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s expected %0h got %0h", $time, what, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin
        frame_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_words.size() == 0)
            begin
                $display("%0t ns: word expected none got %0h/%0h/%0h/%0h/%0h/%0h",
                         $time, function_code, payload_length, byte_index,
                         payload_byte, has_byte, last_of_frame);
                errors++;
            end
            else
            begin
                want = pending_words.pop_front();
                note_field("function_code", want.func, function_code);
                note_field("payload_length", want.len, payload_length);
                note_field("byte_index", want.idx, byte_index);
                note_field("payload_byte", want.data, payload_byte);
                note_field("has_byte", want.has, has_byte);
                note_field("last_of_frame", want.last, last_of_frame);
            end
        end
    end

    initial
    begin
        int frames;
        // junk before any start byte is dropped
        add_row(8'h00, ROW_NO_WORD, '0);
        // zero-length frame, checksum fe^12^34
        add_row(START_BYTE, ROW_PREDICT, '0);
        add_row(8'h12, ROW_PREDICT, '0);
        add_row(8'h34, ROW_PREDICT, '0);
        add_row(8'h00, ROW_PREDICT, '0);
        add_row(8'h00, ROW_PREDICT, '0);
        add_row(8'hD8, ROW_ONE_WORD, {16'h1234, 7'd0, 6'd0, 8'h00, 1'b0, 1'b1});
        // all-ones code and payload, length one
        add_row(START_BYTE, ROW_PREDICT, '0);
        add_row(8'hFF, ROW_PREDICT, '0);
        add_row(8'hFF, ROW_PREDICT, '0);
        add_row(8'h00, ROW_PREDICT, '0);
        add_row(8'h01, ROW_PREDICT, '0);
        add_row(8'hFF, ROW_PREDICT, '0);
        add_row(8'h00, ROW_ONE_WORD, {16'hFFFF, 7'd1, 6'd0, 8'hFF, 1'b1, 1'b1});
        // length 256 is over the limit, frame dropped after the length
        add_row(START_BYTE, ROW_PREDICT, '0);
        add_row(8'h00, ROW_PREDICT, '0);
        add_row(8'h00, ROW_PREDICT, '0);
        add_row(8'h01, ROW_PREDICT, '0);
        add_row(8'h00, ROW_NO_WORD, '0);
        // zero-length frame with a wrong checksum
        add_row(START_BYTE, ROW_PREDICT, '0);
        add_row(8'h00, ROW_PREDICT, '0);
        add_row(8'h00, ROW_PREDICT, '0);
        add_row(8'h00, ROW_PREDICT, '0);
        add_row(8'h00, ROW_PREDICT, '0);
        add_row(8'h00, ROW_NO_WORD, '0);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_rows[i])
        begin
            push_word(stim_rows[i].data, 1'b1, stim_rows[i].mode == ROW_PREDICT);
            if (stim_rows[i].mode == ROW_ONE_WORD)
                pending_words.push_back(stim_rows[i].word);
        end

        frames = 0;
        while (words_sent < RANDOM_WORDS + stim_rows.size())
        begin
            // a stretch with no idling on either side
            calm = (frames >= 12 && frames < 20);
            send_frame();
            frames++;
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (PAYLOAD_MAX + 8) @(posedge clk);

        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
